// File: design/b64sc_pkg.sv
// shared types, constants and alphabet functions for the base64 stream codec
package b64sc_pkg;

    // widths of the stream fields
    localparam int BYTE_W      = 8;
    localparam int SEXTET_W    = 6;
    localparam int COUNT_W     = 3;
    localparam int MAX_RESULTS = 4;
    localparam int SLOT_W      = $clog2(MAX_RESULTS);
    localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

    // pad character '='
    localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

    // direction codes of the mode register
    localparam logic MODE_ENCODE = 1'b0;
    localparam logic MODE_DECODE = 1'b1;

    // one classified input word: up to four result words ready to go out
    typedef struct packed {
        logic [NRES_W-1:0]                  num;
        logic [MAX_RESULTS-1:0][BYTE_W-1:0] bytes;
        logic                               empty;
        logic                               last;
    } b64sc_job_t;

    // sextet value to alphabet character
    function automatic logic [BYTE_W-1:0] enc_char(input logic [SEXTET_W-1:0] v);
        logic [BYTE_W-1:0] ch;
        begin
            if (v < 6'd26)
            begin
                ch = 8'h41 + {2'b00, v};
            end
            else if (v < 6'd52)
            begin
                ch = 8'h61 + {2'b00, v} - 8'd26;
            end
            else if (v < 6'd62)
            begin
                ch = 8'h30 + {2'b00, v} - 8'd52;
            end
            else if (v == 6'd62)
            begin
                ch = 8'h2B;
            end
            else
            begin
                ch = 8'h2F;
            end
            return ch;
        end
    endfunction

    // alphabet character to sextet, top bit set when not in the alphabet
    function automatic logic [SEXTET_W:0] dec_sextet(input logic [BYTE_W-1:0] ch);
        logic [SEXTET_W:0] r;
        begin
            if (ch >= 8'h41 && ch <= 8'h5A)
            begin
                r = {1'b0, 6'(ch - 8'h41)};
            end
            else if (ch >= 8'h61 && ch <= 8'h7A)
            begin
                r = {1'b0, 6'(ch - 8'h61 + 8'd26)};
            end
            else if (ch >= 8'h30 && ch <= 8'h39)
            begin
                r = {1'b0, 6'(ch - 8'h30 + 8'd52)};
            end
            else if (ch == 8'h2B)
            begin
                r = {1'b0, 6'd62};
            end
            else if (ch == 8'h2F)
            begin
                r = {1'b0, 6'd63};
            end
            else
            begin
                r = {1'b1, 6'd0};
            end
            return r;
        end
    endfunction

endpackage

// File: design/b64sc_front.sv
// front end: takes input words, tracks the bit residual and builds result jobs
module b64sc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          in_valid,
    input  logic [b64sc_pkg::BYTE_W-1:0]  in_byte,
    input  logic                          in_last,
    output logic                          in_ready,
    output logic                          job_valid,
    output b64sc_pkg::b64sc_job_t         job,
    input  logic                          job_ready
);
    import b64sc_pkg::*;

    logic                 mode_reg;
    logic [SEXTET_W-1:0]  res_bits_reg, res_bits_next;
    logic [COUNT_W-1:0]   res_count_reg, res_count_next;
    logic                 halted_reg, halted_next;

    logic [COUNT_W-1:0]   cnt;
    logic [3:0]           enc_total;
    logic [13:0]          enc_acc;
    logic                 enc_two;
    logic [COUNT_W-1:0]   enc_rem;
    logic [SEXTET_W-1:0]  enc_rem_bits;
    logic [SEXTET_W:0]    sx;
    logic [3:0]           dec_total;
    logic [11:0]          dec_acc;
    logic                 dec_emit;
    logic [COUNT_W-1:0]   dec_rem;
    logic [SEXTET_W-1:0]  dec_rem_bits;
    logic                 accept;

    assign in_ready  = job_ready;
    assign accept    = in_valid && in_ready;
    assign job_valid = in_valid && (job.num != '0);

    // residual arithmetic for both directions
    always_comb
    begin
        cnt          = (res_count_reg > 3'd6) ? 3'd6 : res_count_reg;
        enc_total    = {1'b0, cnt} + 4'd8;
        enc_acc      = {res_bits_reg, in_byte};
        enc_two      = (enc_total >= 4'd12);
        enc_rem      = enc_two ? 3'(enc_total - 4'd12) : 3'(enc_total - 4'd6);
        enc_rem_bits = 6'(enc_acc & ((14'd1 << enc_rem) - 14'd1));
        sx           = dec_sextet(in_byte);
        dec_total    = {1'b0, cnt} + 4'd6;
        dec_acc      = {res_bits_reg, sx[SEXTET_W-1:0]};
        dec_emit     = (dec_total >= 4'd8);
        dec_rem      = dec_emit ? 3'(dec_total - 4'd8) : 3'(dec_total);
        dec_rem_bits = 6'(dec_acc & ((12'd1 << dec_rem) - 12'd1));
    end

    // job contents and next residual state
    always_comb
    begin
        job            = '0;
        res_bits_next  = res_bits_reg;
        res_count_next = res_count_reg;
        halted_next    = halted_reg;
        if (mode_reg == MODE_ENCODE)
        begin
            job.bytes[0] = enc_char(6'(enc_acc >> (enc_total - 4'd6)));
            job.num      = 3'd1;
            if (enc_two)
            begin
                job.bytes[1] = enc_char(6'(enc_acc >> (enc_total - 4'd12)));
                job.num      = 3'd2;
            end
            if (in_last && enc_rem != 3'd0)
            begin
                job.bytes[job.num[SLOT_W-1:0]] =
                    enc_char(6'(enc_rem_bits << (3'd6 - enc_rem)));
                job.num = job.num + 3'd1;
                // one or two pad characters while room remains
                if (job.num < 3'(MAX_RESULTS))
                begin
                    job.bytes[job.num[SLOT_W-1:0]] = PAD_CHAR;
                    job.num = job.num + 3'd1;
                end
                if (enc_rem == 3'd2 && job.num < 3'(MAX_RESULTS))
                begin
                    job.bytes[job.num[SLOT_W-1:0]] = PAD_CHAR;
                    job.num = job.num + 3'd1;
                end
            end
            res_bits_next  = enc_rem_bits;
            res_count_next = enc_rem;
        end
        else
        begin
            if (!halted_reg)
            begin
                if (sx[SEXTET_W])
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    if (dec_emit)
                    begin
                        job.bytes[0] = 8'(dec_acc >> (dec_total - 4'd8));
                        job.num      = 3'd1;
                    end
                    res_bits_next  = dec_rem_bits;
                    res_count_next = dec_rem;
                end
            end
            // the last word always yields a result
            if (in_last && job.num == '0)
            begin
                job.num   = 3'd1;
                job.empty = 1'b1;
            end
        end
        if (in_last)
        begin
            job.last       = 1'b1;
            res_bits_next  = '0;
            res_count_next = '0;
            halted_next    = 1'b0;
        end
    end

    // mode and residual registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_ENCODE;
            res_bits_reg  <= '0;
            res_count_reg <= '0;
            halted_reg    <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg      <= cfg_wr_data;
            res_bits_reg  <= '0;
            res_count_reg <= '0;
            halted_reg    <= 1'b0;
        end
        else if (accept)
        begin
            res_bits_reg  <= res_bits_next;
            res_count_reg <= res_count_next;
            halted_reg    <= halted_next;
        end
    end

endmodule

// File: design/b64sc_queue.sv
// two-entry job queue between front end and back end
module b64sc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64sc_pkg::b64sc_job_t  push_job,
    output logic                   not_full,
    output logic                   not_empty,
    input  logic                   pop,
    output b64sc_pkg::b64sc_job_t  head_job
);
    import b64sc_pkg::*;

    b64sc_job_t  store_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  fill_reg;
    logic        do_push;
    logic        do_pop;

    assign not_full  = (fill_reg != 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign do_push   = push && not_full;
    assign do_pop    = pop && not_empty;
    assign head_job  = store_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// File: design/b64sc_back.sv
// back end: holds one job and sends its result words one per cycle while out_ready is high
module b64sc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  b64sc_pkg::b64sc_job_t         job,
    output logic                          job_take,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [b64sc_pkg::BYTE_W-1:0]  out_byte,
    output logic                          out_empty,
    output logic                          out_last
);
    import b64sc_pkg::*;

    b64sc_job_t          job_reg;
    logic [SLOT_W-1:0]   idx_reg;
    logic                busy_reg;
    logic                final_word;
    logic                sent;

    assign final_word = (idx_reg == SLOT_W'(job_reg.num - 3'd1));
    assign sent       = busy_reg && out_ready;
    assign job_take   = job_valid && (!busy_reg || (sent && final_word));

    assign out_valid  = busy_reg;
    assign out_byte   = job_reg.bytes[idx_reg];
    assign out_empty  = job_reg.empty;
    assign out_last   = job_reg.last && final_word;

    // job payload
    always_ff @(posedge clk)
    begin
        if (job_take)
        begin
            job_reg <= job;
        end
    end

    // word index and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else if (job_take)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b1;
        end
        else if (sent)
        begin
            if (final_word)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                idx_reg <= idx_reg + SLOT_W'(1);
            end
        end
    end

endmodule

// File: design/base64_stream_codec_unit.sv
// top level of the base64 stream codec: front end, job queue and back end
// Base64 (standard alphabet) codec on a byte stream. cfg_wr_data selects the
// direction (0 encode, 1 decode); a write also drops any message in progress.
// The front end takes one input word per cycle whenever the two-entry job
// queue has room, and the back end sends one result word per cycle while
// m_axis_tready is high. Encoding gives one or two characters per byte (four
// characters per three bytes) and up to four on the word marked tlast;
// decoding gives at most one byte per character. Each result passes through
// a queue entry and then the back end's job register before it goes out.
module base64_stream_codec_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_data,     // decode_mode
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // [7:0] data_byte
    input  logic        s_axis_tlast,    // end_of_message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,    // [7:0] out_byte
    output logic        m_axis_tuser,    // [0] out_empty
    output logic        m_axis_tlast     // out_last
);
    import b64sc_pkg::*;

    b64sc_job_t  front_job;
    b64sc_job_t  head_job;
    logic        front_valid;
    logic        q_not_full;
    logic        q_not_empty;
    logic        back_take;

    // input classification
    b64sc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_byte     (s_axis_tdata),
        .in_last     (s_axis_tlast),
        .in_ready    (s_axis_tready),
        .job_valid   (front_valid),
        .job         (front_job),
        .job_ready   (q_not_full)
    );

    // decoupling queue
    b64sc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_job  (front_job),
        .not_full  (q_not_full),
        .not_empty (q_not_empty),
        .pop       (back_take),
        .head_job  (head_job)
    );

    // result sequencing
    b64sc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_not_empty),
        .job       (head_job),
        .job_take  (back_take),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (m_axis_tdata),
        .out_empty (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

endmodule
